// ===== design/qadp_pkg.sv =====
// Shared types, codes and helpers for the quadratic attractor density plotter.
package qadp_pkg;

    localparam logic [2:0] REQ_START = 3'd0;
    localparam logic [2:0] REQ_ITER  = 3'd1;
    localparam logic [2:0] REQ_PLOT  = 3'd2;
    localparam logic [2:0] REQ_READ  = 3'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_SPAN  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    localparam logic [3:0] CFG_X_CONST_LIN = 4'd0;
    localparam logic [3:0] CFG_X_SQ_LIN    = 4'd1;
    localparam logic [3:0] CFG_X_SQ_CROSS  = 4'd2;
    localparam logic [3:0] CFG_Y_CONST_LIN = 4'd3;
    localparam logic [3:0] CFG_Y_SQ_LIN    = 4'd4;
    localparam logic [3:0] CFG_Y_SQ_CROSS  = 4'd5;
    localparam logic [3:0] CFG_SEED        = 4'd6;
    localparam logic [3:0] CFG_INTENSITY   = 4'd7;

    localparam logic [7:0] PIXEL_MAX      = 8'd255;
    localparam logic [7:0] INTENSITY_INIT = 8'd2;
    localparam int         FRAC_BITS      = 24;

    // multiplier schedule of one iterate
    localparam logic [3:0] MS_XX   = 4'd0;
    localparam logic [3:0] MS_YY   = 4'd1;
    localparam logic [3:0] MS_XY   = 4'd2;
    localparam logic [3:0] MS_C1X  = 4'd3;
    localparam logic [3:0] MS_C2XX = 4'd4;
    localparam logic [3:0] MS_C3Y  = 4'd5;
    localparam logic [3:0] MS_C4YY = 4'd6;
    localparam logic [3:0] MS_C5XY = 4'd7;
    localparam logic [3:0] MS_D1X  = 4'd8;
    localparam logic [3:0] MS_D2XX = 4'd9;
    localparam logic [3:0] MS_D3Y  = 4'd10;
    localparam logic [3:0] MS_D4YY = 4'd11;
    localparam logic [3:0] MS_D5XY = 4'd12;

    typedef struct packed {
        logic       load_req;
        logic       do_start;
        logic       mul_en;
        logic [3:0] mul_sel;
        logic       iter_commit;
        logic       div_load;
        logic       div_init;
        logic       div_step;
        logic       div_take;
        logic       div_axis;
        logic       addr_load;
        logic       addr_plot;
        logic       mem_rd;
        logic       mem_wr;
        logic       pix_take;
        logic       clr_step;
        logic       res_load;
        logic [1:0] res_status;
        logic       res_pix;
    } qadp_cmd_t;

    typedef struct packed {
        logic [2:0] req_kind;
        logic       span_zero;
        logic       out_range;
        logic       read_oob;
        logic       clr_last;
        logic       div_last;
    } qadp_sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
        logic signed [31:0] r;
        if (v > 44'sh0007FFFFFFF)
            r = 32'sh7FFFFFFF;
        else if (v < -44'sh00080000000)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== design/qadp_if.sv =====
// Handshake channel interfaces: request, result and configuration write.
interface qadp_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic signed [31:0] plot_x;
    logic signed [31:0] plot_y;
    logic [9:0]         read_col;
    logic [9:0]         read_row;

    modport source (output valid, req_type, plot_x, plot_y, read_col, read_row, input ready);
    modport sink   (input valid, req_type, plot_x, plot_y, read_col, read_row, output ready);
endinterface

interface qadp_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] bound_x_low;
    logic signed [31:0] bound_x_high;
    logic signed [31:0] bound_y_low;
    logic signed [31:0] bound_y_high;
    logic [7:0]         pixel_value;
    logic [1:0]         status;

    modport source (output valid, point_x, point_y, bound_x_low, bound_x_high, bound_y_low,
                    bound_y_high, pixel_value, status, input ready);
    modport sink   (input valid, point_x, point_y, bound_x_low, bound_x_high, bound_y_low,
                    bound_y_high, pixel_value, status, output ready);
endinterface

interface qadp_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  addr;
    logic [63:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// ===== design/qadp_dp.sv =====
// Datapath: registers, shared multiplier, divider, image store and result register.
module qadp_dp #(
    parameter int IMAGE_WIDTH  = 1024,
    parameter int IMAGE_HEIGHT = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  qadp_pkg::qadp_cmd_t cmd,
    output qadp_pkg::qadp_sts_t sts,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_addr,
    input  logic [63:0]         cfg_data,
    input  logic [2:0]          req_type,
    input  logic signed [31:0]  plot_x,
    input  logic signed [31:0]  plot_y,
    input  logic [9:0]          read_col,
    input  logic [9:0]          read_row,
    output logic signed [31:0]  point_x,
    output logic signed [31:0]  point_y,
    output logic signed [31:0]  bound_x_low,
    output logic signed [31:0]  bound_x_high,
    output logic signed [31:0]  bound_y_low,
    output logic signed [31:0]  bound_y_high,
    output logic [7:0]          pixel_value,
    output logic [1:0]          status
);

    localparam int DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int XB    = $clog2(IMAGE_WIDTH);
    localparam int YB    = $clog2(IMAGE_HEIGHT);
    localparam int AW    = $clog2(DEPTH);
    localparam int QB    = (XB > YB) ? XB : YB;
    localparam int NUMW  = 32 + QB;
    localparam int CW    = $clog2(QB + 1);

    // configuration
    logic [63:0] coef_reg [6];
    logic [63:0] seed_reg;
    logic [7:0]  inten_reg;

    // request copy
    logic [2:0]         kind_reg;
    logic signed [31:0] px_reg, py_reg;
    logic [9:0]         col_reg, row_reg;

    // map state
    logic signed [31:0] map_x_reg, map_y_reg;
    logic signed [31:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;

    // iterate
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_reg;
    logic [3:0]         pstep_reg;
    logic               pvalid_reg;
    logic signed [31:0] xx_reg, yy_reg, xy_reg;
    logic signed [43:0] acc_x_reg, acc_y_reg;
    logic signed [43:0] term;
    logic signed [31:0] nx, ny;

    // divider
    logic [NUMW-1:0]    num_reg;
    logic [31:0]        span_reg, rem_reg;
    logic [QB-1:0]      lo_reg, q_reg;
    logic [CW-1:0]      dcnt_reg;
    logic [32:0]        off_w, span_w, trial;
    logic [QB-1:0]      res1;
    logic               ge;
    logic [XB-1:0]      xi_reg;
    logic [YB-1:0]      yi_reg;

    // image store
    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] addr_reg, clr_addr_reg, wr_addr;
    logic [7:0]    rd_reg, pix_hold_reg, new_pix, wr_data;
    logic          room, we;

    logic signed [31:0] res_px_reg, res_py_reg, res_xl_reg, res_xh_reg, res_yl_reg, res_yh_reg;
    logic [7:0]         res_pix_reg;
    logic [1:0]         res_stat_reg;

    // multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            qadp_pkg::MS_XX:   begin mul_a = map_x_reg;               mul_b = map_x_reg; end
            qadp_pkg::MS_YY:   begin mul_a = map_y_reg;               mul_b = map_y_reg; end
            qadp_pkg::MS_XY:   begin mul_a = map_x_reg;               mul_b = map_y_reg; end
            qadp_pkg::MS_C1X:  begin mul_a = coef_reg[0][31:0];       mul_b = map_x_reg; end
            qadp_pkg::MS_C2XX: begin mul_a = coef_reg[1][63:32];      mul_b = xx_reg;    end
            qadp_pkg::MS_C3Y:  begin mul_a = coef_reg[1][31:0];       mul_b = map_y_reg; end
            qadp_pkg::MS_C4YY: begin mul_a = coef_reg[2][63:32];      mul_b = yy_reg;    end
            qadp_pkg::MS_C5XY: begin mul_a = coef_reg[2][31:0];       mul_b = xy_reg;    end
            qadp_pkg::MS_D1X:  begin mul_a = coef_reg[3][31:0];       mul_b = map_x_reg; end
            qadp_pkg::MS_D2XX: begin mul_a = coef_reg[4][63:32];      mul_b = xx_reg;    end
            qadp_pkg::MS_D3Y:  begin mul_a = coef_reg[4][31:0];       mul_b = map_y_reg; end
            qadp_pkg::MS_D4YY: begin mul_a = coef_reg[5][63:32];      mul_b = yy_reg;    end
            qadp_pkg::MS_D5XY: begin mul_a = coef_reg[5][31:0];       mul_b = xy_reg;    end
            default:           begin mul_a = '0;                      mul_b = '0;        end
        endcase
    end

    // floor shift of the registered product, sign extended
    assign term = 44'(prod_reg >>> qadp_pkg::FRAC_BITS);
    assign nx   = qadp_pkg::sat32(acc_x_reg);
    assign ny   = qadp_pkg::sat32(acc_y_reg);

    // divider operands per axis
    always_comb
    begin
        if (cmd.div_axis)
        begin
            off_w  = 33'(py_reg) - 33'(min_y_reg);
            span_w = 33'(max_y_reg) - 33'(min_y_reg);
            res1   = QB'(IMAGE_HEIGHT - 1);
        end
        else
        begin
            off_w  = 33'(px_reg) - 33'(min_x_reg);
            span_w = 33'(max_x_reg) - 33'(min_x_reg);
            res1   = QB'(IMAGE_WIDTH - 1);
        end
    end

    assign trial = {rem_reg, lo_reg[QB-1]};
    assign ge    = trial >= {1'b0, span_reg};

    assign new_pix = rd_reg + inten_reg;
    assign room    = rd_reg <= (qadp_pkg::PIXEL_MAX - inten_reg);
    assign we      = cmd.clr_step | (cmd.mem_wr & room);
    assign wr_addr = cmd.clr_step ? clr_addr_reg : addr_reg;
    assign wr_data = cmd.clr_step ? 8'd0 : new_pix;

    assign sts.req_kind  = kind_reg;
    assign sts.span_zero = (max_x_reg == min_x_reg) || (max_y_reg == min_y_reg);
    assign sts.out_range = (px_reg < min_x_reg) || (px_reg > max_x_reg)
                        || (py_reg < min_y_reg) || (py_reg > max_y_reg);
    assign sts.read_oob  = (32'(col_reg) >= 32'(IMAGE_WIDTH)) || (32'(row_reg) >= 32'(IMAGE_HEIGHT));
    assign sts.clr_last  = clr_addr_reg == AW'(DEPTH - 1);
    assign sts.div_last  = dcnt_reg == CW'(QB - 1);

    // control-bearing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                coef_reg[i] <= '0;
            seed_reg     <= '0;
            inten_reg    <= qadp_pkg::INTENSITY_INIT;
            map_x_reg    <= '0;
            map_y_reg    <= '0;
            min_x_reg    <= '0;
            max_x_reg    <= '0;
            min_y_reg    <= '0;
            max_y_reg    <= '0;
            pvalid_reg   <= 1'b0;
            clr_addr_reg <= '0;
            dcnt_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    qadp_pkg::CFG_X_CONST_LIN: coef_reg[0] <= cfg_data;
                    qadp_pkg::CFG_X_SQ_LIN:    coef_reg[1] <= cfg_data;
                    qadp_pkg::CFG_X_SQ_CROSS:  coef_reg[2] <= cfg_data;
                    qadp_pkg::CFG_Y_CONST_LIN: coef_reg[3] <= cfg_data;
                    qadp_pkg::CFG_Y_SQ_LIN:    coef_reg[4] <= cfg_data;
                    qadp_pkg::CFG_Y_SQ_CROSS:  coef_reg[5] <= cfg_data;
                    qadp_pkg::CFG_SEED:        seed_reg    <= cfg_data;
                    qadp_pkg::CFG_INTENSITY:   inten_reg   <= cfg_data[7:0];
                    default:                   ;
                endcase
            end

            if (cmd.do_start)
            begin
                map_x_reg <= seed_reg[63:32];
                map_y_reg <= seed_reg[31:0];
                min_x_reg <= '0;
                max_x_reg <= '0;
                min_y_reg <= '0;
                max_y_reg <= '0;
            end
            else if (cmd.iter_commit)
            begin
                map_x_reg <= nx;
                map_y_reg <= ny;
                if (nx < min_x_reg) min_x_reg <= nx;
                if (nx > max_x_reg) max_x_reg <= nx;
                if (ny < min_y_reg) min_y_reg <= ny;
                if (ny > max_y_reg) max_y_reg <= ny;
            end

            pvalid_reg <= cmd.mul_en;

            if (cmd.clr_step)
                clr_addr_reg <= clr_addr_reg + AW'(1);

            if (cmd.div_init)
                dcnt_reg <= '0;
            else if (cmd.div_step)
                dcnt_reg <= dcnt_reg + CW'(1);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            kind_reg <= req_type;
            px_reg   <= plot_x;
            py_reg   <= plot_y;
            col_reg  <= read_col;
            row_reg  <= read_row;
        end

        if (cmd.mul_en)
        begin
            prod_reg  <= mul_a * mul_b;
            pstep_reg <= cmd.mul_sel;
        end

        if (cmd.do_start)
        begin
            acc_x_reg <= 44'(signed'(coef_reg[0][63:32]));
            acc_y_reg <= 44'(signed'(coef_reg[3][63:32]));
        end
        else if (cmd.iter_commit)
        begin
            acc_x_reg <= 44'(signed'(coef_reg[0][63:32]));
            acc_y_reg <= 44'(signed'(coef_reg[3][63:32]));
        end
        else if (pvalid_reg)
        begin
            case (pstep_reg)
                qadp_pkg::MS_XX: xx_reg <= qadp_pkg::sat32(term);
                qadp_pkg::MS_YY: yy_reg <= qadp_pkg::sat32(term);
                qadp_pkg::MS_XY: xy_reg <= qadp_pkg::sat32(term);
                qadp_pkg::MS_C1X, qadp_pkg::MS_C2XX, qadp_pkg::MS_C3Y,
                qadp_pkg::MS_C4YY, qadp_pkg::MS_C5XY:
                    acc_x_reg <= acc_x_reg + term;
                default:
                    acc_y_reg <= acc_y_reg + term;
            endcase
        end
        else if (cmd.load_req)
        begin
            // an iterate starts from the constant terms
            acc_x_reg <= 44'(signed'(coef_reg[0][63:32]));
            acc_y_reg <= 44'(signed'(coef_reg[3][63:32]));
        end

        if (cmd.div_load)
        begin
            num_reg  <= off_w[31:0] * NUMW'(res1);
            span_reg <= span_w[31:0];
        end
        if (cmd.div_init)
        begin
            rem_reg <= num_reg[NUMW-1:QB];
            lo_reg  <= num_reg[QB-1:0];
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? 32'(trial - {1'b0, span_reg}) : trial[31:0];
            lo_reg  <= lo_reg << 1;
            q_reg   <= (q_reg << 1) | QB'(ge);
        end
        if (cmd.div_take)
        begin
            if (cmd.div_axis)
                yi_reg <= q_reg[YB-1:0];
            else
                xi_reg <= q_reg[XB-1:0];
        end

        if (cmd.addr_load)
        begin
            if (cmd.addr_plot)
                addr_reg <= AW'(yi_reg) * AW'(IMAGE_WIDTH) + AW'(xi_reg);
            else
                addr_reg <= AW'(row_reg) * AW'(IMAGE_WIDTH) + AW'(col_reg);
        end

        if (cmd.mem_wr)
            pix_hold_reg <= room ? new_pix : rd_reg;
        else if (cmd.pix_take)
            pix_hold_reg <= rd_reg;

        if (cmd.res_load)
        begin
            res_px_reg   <= map_x_reg;
            res_py_reg   <= map_y_reg;
            res_xl_reg   <= min_x_reg;
            res_xh_reg   <= max_x_reg;
            res_yl_reg   <= min_y_reg;
            res_yh_reg   <= max_y_reg;
            res_pix_reg  <= cmd.res_pix ? pix_hold_reg : 8'd0;
            res_stat_reg <= cmd.res_status;
        end
    end

    // image store, one port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wr_data;
        if (cmd.mem_rd)
            rd_reg <= mem[addr_reg];
    end

    assign point_x      = res_px_reg;
    assign point_y      = res_py_reg;
    assign bound_x_low  = res_xl_reg;
    assign bound_x_high = res_xh_reg;
    assign bound_y_low  = res_yl_reg;
    assign bound_y_high = res_yh_reg;
    assign pixel_value  = res_pix_reg;
    assign status       = res_stat_reg;

endmodule

// ===== design/qadp_ctrl.sv =====
// Controller: sequences each request over the datapath and owns the handshakes.
module qadp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  qadp_pkg::qadp_sts_t sts,
    output qadp_pkg::qadp_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_ITER,
        ST_ITER_ACC,
        ST_ITER_CMT,
        ST_DIV_MUL,
        ST_DIV_INIT,
        ST_DIV_RUN,
        ST_DIV_TAKE,
        ST_ADDR,
        ST_MEM_RD,
        ST_MEM_WR,
        ST_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       axis_reg, axis_next;
    logic       plot_reg, plot_next;
    logic [1:0] stat_reg, stat_next;
    logic       pixf_reg, pixf_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        plot_next  = plot_reg;
        stat_next  = stat_reg;
        pixf_next  = pixf_reg;
        cmd        = '0;
        cmd.div_axis = axis_reg;
        in_ready   = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                stat_next  = qadp_pkg::STAT_OK;
                pixf_next  = 1'b0;
                plot_next  = sts.req_kind == qadp_pkg::REQ_PLOT;
                axis_next  = 1'b0;
                cnt_next   = '0;
                state_next = ST_FINISH;
                case (sts.req_kind)
                    qadp_pkg::REQ_START: cmd.do_start = 1'b1;
                    qadp_pkg::REQ_ITER:  state_next = ST_ITER;
                    qadp_pkg::REQ_PLOT:
                    begin
                        if (sts.span_zero)
                            stat_next = qadp_pkg::STAT_SPAN;
                        else if (sts.out_range)
                            stat_next = qadp_pkg::STAT_RANGE;
                        else
                            state_next = ST_DIV_MUL;
                    end
                    qadp_pkg::REQ_READ:
                    begin
                        if (sts.read_oob)
                            stat_next = qadp_pkg::STAT_RANGE;
                        else
                            state_next = ST_ADDR;
                    end
                    default: ;
                endcase
            end
            ST_ITER:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = cnt_reg;
                cnt_next    = cnt_reg + 4'd1;
                if (cnt_reg == qadp_pkg::MS_D5XY)
                    state_next = ST_ITER_ACC;
            end
            ST_ITER_ACC: state_next = ST_ITER_CMT;
            ST_ITER_CMT:
            begin
                cmd.iter_commit = 1'b1;
                state_next      = ST_FINISH;
            end
            ST_DIV_MUL:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = ST_DIV_TAKE;
            end
            ST_DIV_TAKE:
            begin
                cmd.div_take = 1'b1;
                if (axis_reg)
                    state_next = ST_ADDR;
                else
                begin
                    axis_next  = 1'b1;
                    state_next = ST_DIV_MUL;
                end
            end
            ST_ADDR:
            begin
                cmd.addr_load = 1'b1;
                cmd.addr_plot = plot_reg;
                state_next    = ST_MEM_RD;
            end
            ST_MEM_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_MEM_WR;
            end
            ST_MEM_WR:
            begin
                cmd.mem_wr   = plot_reg;
                cmd.pix_take = !plot_reg;
                pixf_next    = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = stat_reg;
                    cmd.res_pix    = pixf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.res_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            axis_reg      <= 1'b0;
            plot_reg      <= 1'b0;
            stat_reg      <= qadp_pkg::STAT_OK;
            pixf_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            axis_reg      <= axis_next;
            plot_reg      <= plot_next;
            stat_reg      <= stat_next;
            pixf_reg      <= pixf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/quadratic_attractor_density_plotter.sv =====
// Top level of the quadratic attractor density plotter.
// Iterates a 12-coefficient quadratic map in signed Q8.24, tracks the bounds of
// every iterate and accumulates hits in an IMAGE_WIDTH x IMAGE_HEIGHT
// 8-bit density image held in a single-port on-chip memory. Each request beat
// gives exactly one result beat, which carries the current point and bounds.
// Each request is sequenced over the datapath: start and no-op go straight
// to the result; an iterate makes thirteen passes through one registered
// 32x32 multiplier, then accumulates and commits; a read forms the address,
// reads the store and takes the pixel; and a plot that passes its checks
// runs two restoring divisions, one quotient bit a cycle on a shared divider,
// then reads and updates the pixel. One request is in flight at a time; the
// next beat is taken once the current one has been handed to the result
// register. After reset the image is cleared one pixel a cycle, during which
// no request is taken; configuration writes are taken at any time.
module quadratic_attractor_density_plotter #(
    parameter int IMAGE_WIDTH  = 1024,
    parameter int IMAGE_HEIGHT = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    qadp_cfg_if.sink    cfg,
    qadp_req_if.sink    req,
    qadp_res_if.source  res
);

    qadp_pkg::qadp_cmd_t cmd;
    qadp_pkg::qadp_sts_t sts;
    logic                cfg_we;

    // configuration is always taken
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    qadp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    qadp_dp #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg.addr),
        .cfg_data     (cfg.data),
        .req_type     (req.req_type),
        .plot_x       (req.plot_x),
        .plot_y       (req.plot_y),
        .read_col     (req.read_col),
        .read_row     (req.read_row),
        .point_x      (res.point_x),
        .point_y      (res.point_y),
        .bound_x_low  (res.bound_x_low),
        .bound_x_high (res.bound_x_high),
        .bound_y_low  (res.bound_y_low),
        .bound_y_high (res.bound_y_high),
        .pixel_value  (res.pixel_value),
        .status       (res.status)
    );

    // bounds always straddle the origin, since start clears them to zero
    a_bounds_origin: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.bound_x_low <= 0) && (res.bound_x_high >= 0)
                   && (res.bound_y_low <= 0) && (res.bound_y_high >= 0))
        else $error("bounds do not straddle origin");

    // an error beat never carries a pixel
    a_err_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.status != qadp_pkg::STAT_OK) |-> res.pixel_value == 8'd0)
        else $error("pixel on error beat");

    // a zero-span error must match the bounds it reports
    a_span_match: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.status == qadp_pkg::STAT_SPAN)
            |-> (res.bound_x_low == res.bound_x_high) || (res.bound_y_low == res.bound_y_high))
        else $error("zero span status with non-zero span");

endmodule

// ===== sim/tb_quadratic_attractor_density_plotter.sv =====
// Self-checking testbench for the quadratic attractor density plotter.
`timescale 1ns / 1ps

module tb_quadratic_attractor_density_plotter;

    localparam int         IMG_W    = 1024;
    localparam int         IMG_H    = 1024;
    localparam logic [2:0] REQ_IDLE = 3'd4;    // lowest of the unused codes
    localparam int         SETTLE   = 40;      // longer than the slowest plot

    typedef struct {
        logic [2:0]         kind;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [9:0]         col;
        logic [9:0]         row;
    } req_beat_t;

    typedef struct {
        logic signed [31:0] pt_x;
        logic signed [31:0] pt_y;
        logic signed [31:0] lo_x;
        logic signed [31:0] hi_x;
        logic signed [31:0] lo_y;
        logic signed [31:0] hi_y;
        logic [7:0]         pixel;
        logic [1:0]         status;
    } plot_result_t;

    // Holds its own copy of the map, bounds, image and registers, and the
    // queue of results owed by the block.
    class density_scoreboard;
        logic [63:0]  regs [8];
        longint       mx, my, lox, hix, loy, hiy;
        bit [7:0]     image [0:IMG_W*IMG_H-1];
        plot_result_t owed [$];
        int           errors, checked, hits, saturated, span_fails, range_fails;
        int           iters, reads;
        int unsigned  hit_col, hit_row;

        function new();
            foreach (regs[i]) regs[i] = '0;
            regs[qadp_pkg::CFG_INTENSITY] = 64'(qadp_pkg::INTENSITY_INIT);
            mx = 0; my = 0; lox = 0; hix = 0; loy = 0; hiy = 0;
        endfunction

        function void write_reg(logic [3:0] idx, logic [63:0] val);
            if (idx == qadp_pkg::CFG_INTENSITY)
                regs[idx] = {56'd0, val[7:0]};
            else if (idx < 8)
                regs[idx] = val;
        endfunction

        function longint upper(logic [63:0] v);
            return longint'($signed(v[63:32]));
        endfunction

        function longint lower(logic [63:0] v);
            return longint'($signed(v[31:0]));
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // one output coordinate of the map from three packed registers
        function longint map_axis(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                                  longint xx, longint yy, longint xy);
            longint s;
            s = upper(r0);
            s += (lower(r0) * mx) >>> qadp_pkg::FRAC_BITS;
            s += (upper(r1) * xx) >>> qadp_pkg::FRAC_BITS;
            s += (lower(r1) * my) >>> qadp_pkg::FRAC_BITS;
            s += (upper(r2) * yy) >>> qadp_pkg::FRAC_BITS;
            s += (lower(r2) * xy) >>> qadp_pkg::FRAC_BITS;
            return clamp32(s);
        endfunction

        function void note_request(req_beat_t b);
            plot_result_t r;
            longint xx, yy, xy, nx, ny, px, py, xi, yi;
            int unsigned adr, cur, inten;
            r.pixel  = '0;
            r.status = qadp_pkg::STAT_OK;
            px = longint'(b.px);
            py = longint'(b.py);
            case (b.kind)
                qadp_pkg::REQ_START:
                begin
                    mx = upper(regs[qadp_pkg::CFG_SEED]);
                    my = lower(regs[qadp_pkg::CFG_SEED]);
                    lox = 0; hix = 0; loy = 0; hiy = 0;
                end
                qadp_pkg::REQ_ITER:
                begin
                    iters++;
                    xx = clamp32((mx * mx) >>> qadp_pkg::FRAC_BITS);
                    yy = clamp32((my * my) >>> qadp_pkg::FRAC_BITS);
                    xy = clamp32((mx * my) >>> qadp_pkg::FRAC_BITS);
                    nx = map_axis(regs[qadp_pkg::CFG_X_CONST_LIN], regs[qadp_pkg::CFG_X_SQ_LIN],
                                  regs[qadp_pkg::CFG_X_SQ_CROSS], xx, yy, xy);
                    ny = map_axis(regs[qadp_pkg::CFG_Y_CONST_LIN], regs[qadp_pkg::CFG_Y_SQ_LIN],
                                  regs[qadp_pkg::CFG_Y_SQ_CROSS], xx, yy, xy);
                    mx = nx;
                    my = ny;
                    if (nx < lox) lox = nx;
                    if (ny < loy) loy = ny;
                    if (nx > hix) hix = nx;
                    if (ny > hiy) hiy = ny;
                end
                qadp_pkg::REQ_PLOT:
                begin
                    if (hix == lox || hiy == loy) begin
                        r.status = qadp_pkg::STAT_SPAN;
                        span_fails++;
                    end else if (px < lox || px > hix || py < loy || py > hiy) begin
                        r.status = qadp_pkg::STAT_RANGE;
                        range_fails++;
                    end else begin
                        xi = ((px - lox) * (IMG_W - 1)) / (hix - lox);
                        yi = ((py - loy) * (IMG_H - 1)) / (hiy - loy);
                        adr = int'(yi) * IMG_W + int'(xi);
                        inten = regs[qadp_pkg::CFG_INTENSITY][7:0];
                        cur = image[adr];
                        if (cur <= 255 - inten) begin
                            cur += inten;
                            image[adr] = cur[7:0];
                        end else begin
                            saturated++;
                        end
                        r.pixel = cur[7:0];
                        hit_col = xi;
                        hit_row = yi;
                        hits++;
                    end
                end
                qadp_pkg::REQ_READ:
                begin
                    reads++;
                    if (b.col >= IMG_W || b.row >= IMG_H)
                        r.status = qadp_pkg::STAT_RANGE;
                    else
                        r.pixel = image[int'(b.row) * IMG_W + int'(b.col)];
                end
                default: ;
            endcase
            r.pt_x = mx[31:0];
            r.pt_y = my[31:0];
            r.lo_x = lox[31:0];
            r.hi_x = hix[31:0];
            r.lo_y = loy[31:0];
            r.hi_y = hiy[31:0];
            owed.push_back(r);
        endfunction

        function void check_result(plot_result_t got);
            plot_result_t want;
            checked++;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: result beat with nothing owed");
                return;
            end
            want = owed.pop_front();
            if (got.pt_x !== want.pt_x || got.pt_y !== want.pt_y ||
                got.lo_x !== want.lo_x || got.hi_x !== want.hi_x ||
                got.lo_y !== want.lo_y || got.hi_y !== want.hi_y ||
                got.pixel !== want.pixel || got.status !== want.status) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: beat %0d exp pt %h,%h x %h..%h y %h..%h pix %h st %h; got pt %h,%h x %h..%h y %h..%h pix %h st %h",
                             checked, want.pt_x, want.pt_y, want.lo_x, want.hi_x,
                             want.lo_y, want.hi_y, want.pixel, want.status,
                             got.pt_x, got.pt_y, got.lo_x, got.hi_x,
                             got.lo_y, got.hi_y, got.pixel, got.status);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    qadp_cfg_if cfg_ch ();
    qadp_req_if req_ch ();
    qadp_res_if res_ch ();

    quadratic_attractor_density_plotter #(
        .IMAGE_WIDTH  (IMG_W),
        .IMAGE_HEIGHT (IMG_H)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch.sink),
        .req   (req_ch.sink),
        .res   (res_ch.source)
    );

    density_scoreboard sb;
    bit brisk;        // phase with no idling on either side
    bit hold_off;     // long receiver stall in progress
    int accepted;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    // generous limit that also covers the clearing pass after reset
    initial
    begin
        #40ms;
        $display("DONE: errors detected");
        $finish;
    end

    // config write: one beat, then valid is held low until the next edge so it
    // is never re-raised in the step that lowered it
    task automatic write_cfg(logic [3:0] idx, logic [63:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.write_reg(idx, val);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering, wait for every owed beat, then let any tail of work drain
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_req(logic [2:0] kind, logic [31:0] px, logic [31:0] py,
                            logic [9:0] col, logic [9:0] row);
        req_beat_t b;
        int gap;
        gap = brisk ? 0 : $urandom_range(5);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        b.kind = kind; b.px = px; b.py = py; b.col = col; b.row = row;
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.plot_x   <= px;
        req_ch.plot_y   <= py;
        req_ch.read_col <= col;
        req_ch.read_row <= row;
        do @(posedge clk); while (!req_ch.ready);
        sb.note_request(b);
        accepted++;
    endtask

    task automatic send_op(logic [2:0] kind);
        send_req(kind, $urandom, $urandom, $urandom_range(1023), $urandom_range(1023));
    endtask

    task automatic send_plot(logic [31:0] px, logic [31:0] py);
        send_req(qadp_pkg::REQ_PLOT, px, py, $urandom_range(1023), $urandom_range(1023));
    endtask

    task automatic send_read(int unsigned col, int unsigned row);
        send_req(qadp_pkg::REQ_READ, $urandom, $urandom, col[9:0], row[9:0]);
    endtask

    // a value between lo and hi inclusive
    function automatic logic [31:0] pick_between(longint lo, longint hi);
        longint unsigned r;
        r = $urandom;
        return 32'(lo + longint'(r % longint'(hi - lo + 1)));
    endfunction

    // modest Q8.24 coefficient, roughly within +/-1.2
    function automatic logic [31:0] modest_q();
        int v;
        v = int'($urandom_range(40000000)) - 20000000;
        return v;
    endfunction

    function automatic logic [31:0] extreme_q();
        case ($urandom_range(3))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h00000000;
            default: return 32'hFFFFFFFF;
        endcase
    endfunction

    // receiver: random stalls per beat, a long hold-off when asked
    initial
    begin
        plot_result_t got;
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = brisk ? 0 : $urandom_range(5);
            if (stall > 0 || hold_off)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (hold_off) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            got.pt_x   = res_ch.point_x;
            got.pt_y   = res_ch.point_y;
            got.lo_x   = res_ch.bound_x_low;
            got.hi_x   = res_ch.bound_x_high;
            got.lo_y   = res_ch.bound_y_low;
            got.hi_y   = res_ch.bound_y_high;
            got.pixel  = res_ch.pixel_value;
            got.status = res_ch.status;
            sb.check_result(got);
        end
    end

    // one long receiver stall while the sender keeps offering beats,
    // so the block fills and pushes back on its input
    initial
    begin
        wait (accepted >= 300);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        int n, k, roll, phase;
        sb = new();
        brisk    = 1'b0;
        hold_off = 1'b0;
        accepted = 0;
        rst_n    = 1'b0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.addr     <= '0;
        cfg_ch.data     <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= '0;
        req_ch.plot_x   <= '0;
        req_ch.plot_y   <= '0;
        req_ch.read_col <= '0;
        req_ch.read_row <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: fresh state, zero span, reads at both image corners
        send_op(REQ_IDLE);
        send_plot(32'h0, 32'h0);
        send_read(0, 0);
        send_read(IMG_W - 1, IMG_H - 1);
        send_op(qadp_pkg::REQ_START);
        send_op(qadp_pkg::REQ_ITER);
        send_plot(32'h7FFFFFFF, 32'h80000000);
        settle();

        // x' = 1.0, y' = -1.0: bounds become x 0..1, y -1..0
        write_cfg(qadp_pkg::CFG_X_CONST_LIN, {32'h01000000, 32'h0});
        write_cfg(qadp_pkg::CFG_Y_CONST_LIN, {32'hFF000000, 32'h0});
        write_cfg(qadp_pkg::CFG_INTENSITY, 64'd255);
        send_op(qadp_pkg::REQ_START);
        send_op(qadp_pkg::REQ_ITER);
        send_plot(32'h0, 32'hFF000000);      // lower corner
        send_plot(32'h0, 32'hFF000000);      // same pixel again: saturated
        send_plot(32'h01000000, 32'h0);      // upper corner
        send_plot(32'h01000001, 32'h0);      // just past max x
        send_plot(32'h0, 32'hFEFFFFFF);      // just below min y
        send_plot(32'h80000000, 32'h7FFFFFFF);
        send_read(0, 0);
        send_read(IMG_W - 1, IMG_H - 1);
        send_op(3'd5);
        send_op(3'd6);
        send_op(3'd7);
        settle();
        write_cfg(qadp_pkg::CFG_INTENSITY, 64'd0);
        send_plot(32'h00800000, 32'hFF800000);   // zero intensity leaves pixel
        settle();
        write_cfg(4'd8, '1);                     // beyond the register file
        write_cfg(4'd15, 64'h0123456789ABCDEF);
        send_plot(32'h00800000, 32'hFF800000);

        // --- random phases: new register set each time, then runs of
        // start / iterate with plots mostly aimed inside the bounds, reads and no-ops
        for (phase = 0; phase < 10; phase++)
        begin
            settle();
            brisk = (phase % 3 == 2);
            for (k = 0; k < 6; k++)
            begin
                case (phase)
                    0: write_cfg(k[3:0], '0);
                    1: write_cfg(k[3:0], '1);
                    2: write_cfg(k[3:0], {extreme_q(), extreme_q()});
                    default: write_cfg(k[3:0], {modest_q(), modest_q()});
                endcase
            end
            write_cfg(qadp_pkg::CFG_SEED, {modest_q(), modest_q()});
            case (phase % 4)
                0: write_cfg(qadp_pkg::CFG_INTENSITY, 64'd255);
                1: write_cfg(qadp_pkg::CFG_INTENSITY, 64'd1);
                2: write_cfg(qadp_pkg::CFG_INTENSITY, 64'd0);
                default: write_cfg(qadp_pkg::CFG_INTENSITY, {$urandom, $urandom});
            endcase
            write_cfg(4'(8 + $urandom_range(7)), {$urandom, $urandom});

            send_op(qadp_pkg::REQ_START);
            n = $urandom_range(8, 30);
            repeat (n) send_op(qadp_pkg::REQ_ITER);
            repeat (200 - n)
            begin
                roll = $urandom_range(99);
                if (roll < 25)
                    send_op(qadp_pkg::REQ_ITER);
                else if (roll < 65)
                    send_plot(pick_between(sb.lox, sb.hix), pick_between(sb.loy, sb.hiy));
                else if (roll < 72)
                    send_plot($urandom, $urandom);
                else if (roll < 75)
                    send_plot($urandom_range(1) ? sb.lox[31:0] : sb.hix[31:0],
                              $urandom_range(1) ? sb.loy[31:0] : sb.hiy[31:0]);
                else if (roll < 88)
                    send_read(sb.hit_col, sb.hit_row);
                else if (roll < 94)
                    send_read($urandom_range(1023), $urandom_range(1023));
                else if (roll < 97)
                    send_op(qadp_pkg::REQ_START);
                else
                    send_op(3'($urandom_range(4, 7)));
            end
        end

        settle();
        $display("Summary: %0d requests, %0d iterates, %0d pixel hits (%0d saturated), %0d reads",
                 accepted, sb.iters, sb.hits, sb.saturated, sb.reads);
        $display("Summary: %0d zero-span and %0d out-of-bounds plots, 10 register settings",
                 sb.span_fails, sb.range_fails);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
design/qadp_pkg.sv
design/qadp_if.sv
design/qadp_dp.sv
design/qadp_ctrl.sv
design/quadratic_attractor_density_plotter.sv
sim/tb_quadratic_attractor_density_plotter.sv
